/* hw/rtl/jsu_pkg.sv */
// Shared types and constants for the JSON string unescaper.
// Holds the result kind codes, character and byte codes, code point limits, the result bundle type and a hex decoder.
// No dependencies.
package jsu_pkg;

    // Kind of one result transaction, carried on the master-side tuser.
    typedef enum logic [1:0]
    {
        KIND_DATA  = 2'd0,
        KIND_CLOSE = 2'd1,
        KIND_ERROR = 2'd2
    } kind_t;

    // Characters with a meaning to the scanner.
    localparam logic [7:0] CHAR_QUOTE     = 8'h22;
    localparam logic [7:0] CHAR_BACKSLASH = 8'h5c;
    localparam logic [7:0] CHAR_SLASH     = 8'h2f;
    localparam logic [7:0] CHAR_N         = 8'h6e;
    localparam logic [7:0] CHAR_R         = 8'h72;
    localparam logic [7:0] CHAR_T         = 8'h74;
    localparam logic [7:0] CHAR_B         = 8'h62;
    localparam logic [7:0] CHAR_F         = 8'h66;
    localparam logic [7:0] CHAR_U         = 8'h75;
    localparam logic [7:0] CHAR_SPACE     = 8'h20;

    // Bytes that the escapes stand for.
    localparam logic [7:0] BYTE_LF = 8'h0a;
    localparam logic [7:0] BYTE_CR = 8'h0d;
    localparam logic [7:0] BYTE_HT = 8'h09;
    localparam logic [7:0] BYTE_BS = 8'h08;
    localparam logic [7:0] BYTE_FF = 8'h0c;

    // Code point limits and UTF-8 lead and continuation marks.
    localparam logic [15:0] SURR_LOW   = 16'hd800;
    localparam logic [15:0] SURR_HIGH  = 16'hdfff;
    localparam logic [15:0] LIMIT_ONE  = 16'h0080;
    localparam logic [15:0] LIMIT_TWO  = 16'h0800;
    localparam logic [7:0]  LEAD_TWO   = 8'hc0;
    localparam logic [7:0]  LEAD_THREE = 8'he0;
    localparam logic [7:0]  CONT_MARK  = 8'h80;

    // All results caused by one input byte: up to three bytes of one kind.
    typedef struct packed
    {
        logic [1:0]      count;
        logic [2:0][7:0] bytes;
        kind_t           kind;
        logic            last;
    } result_t;

    // Hex digit decode: bit 4 is set for a valid digit, bits 3:0 hold its value.
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            r = {1'b1, 4'(c - 8'h30)};
        end
        else if (c >= 8'h61 && c <= 8'h66)
        begin
            r = {1'b1, 4'(c - 8'h57)};
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            r = {1'b1, 4'(c - 8'h37)};
        end
        return r;
    endfunction

endpackage

/* hw/rtl/jsu_result_buf.sv */
// Result buffer of the JSON string unescaper.
// Holds the results of one input byte and hands them out one per transaction.
// Depends on jsu_pkg.
module jsu_result_buf
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  jsu_pkg::result_t  result,
    output logic              can_load,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [7:0]        m_tdata,   // out_byte[7:0]
    output logic [1:0]        m_tuser,   // result_kind[1:0]
    output logic              m_tlast    // run_last
);

    logic [1:0]      left_reg;
    logic [2:0][7:0] bytes_reg;
    jsu_pkg::kind_t  kind_reg;
    logic            last_reg;
    logic            pop;

    // A new bundle may enter once the last held result leaves.
    assign pop      = m_tvalid && m_tready;
    assign can_load = (left_reg == 2'd0) || (left_reg == 2'd1 && pop);

    // Count and control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg <= 2'd0;
        end
        else if (load)
        begin
            left_reg <= result.count;
        end
        else if (pop)
        begin
            left_reg <= left_reg - 2'd1;
        end
    end

    // Payload: load a bundle, or shift the next byte to the front.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            bytes_reg <= result.bytes;
            kind_reg  <= result.kind;
            last_reg  <= result.last;
        end
        else if (pop)
        begin
            bytes_reg <= {8'h00, bytes_reg[2:1]};
        end
    end

    assign m_tvalid = (left_reg != 2'd0);
    assign m_tdata  = bytes_reg[0];
    assign m_tuser  = kind_reg;
    assign m_tlast  = (left_reg == 2'd1) && last_reg;

endmodule

/* hw/rtl/json_string_unescaper_unit.sv */
// JSON string unescaper, top level.
// Scanner state machine with input register; feeds jsu_result_buf.
// Depends on jsu_pkg and jsu_result_buf.
//
// Use: the slave-side stream carries the raw bytes of quoted JSON strings,
// tdata holding the byte and tlast marking the last byte of available input.
// The master-side stream returns the unescaped content: tdata is the data
// byte, tuser the kind (data, string closed, syntax error) and tlast marks
// the final result caused by an input byte (not set on an error found in the
// byte itself). An input byte gives zero to three results; a \u escape
// gives one to three UTF-8 bytes. An accepted byte is decoded from the
// input register, and its results are loaded into the result buffer.
// Throughput: one input byte per cycle while each byte gives at most one
// result and the receiver is ready; a larger bundle holds the output port
// until all its results are taken from the result buffer, one per cycle.
// Reset clears the scanner to idle (awaiting an opening quote) and empties
// both the input register and the result buffer.
// A stalled receiver holds the current result; at most one more input byte is
// taken into the input register before tready falls.
module json_string_unescaper_unit
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,    // in_byte[7:0]
    input  logic       s_tlast,    // in_final
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,    // out_byte[7:0]
    output logic [1:0] m_tuser,    // result_kind[1:0]
    output logic       m_tlast     // run_last
);

    typedef enum logic [1:0]
    {
        MODE_IDLE,
        MODE_TEXT,
        MODE_ESC,
        MODE_HEX
    } mode_t;

    mode_t             mode_reg,  mode_next;
    logic [1:0]        hex_reg,   hex_next;
    logic [15:0]       acc_reg,   acc_next;
    logic              in_vld_reg;
    logic [7:0]        in_byte_reg;
    logic              in_final_reg;
    jsu_pkg::result_t  res_next;
    logic              can_load;
    logic              process;
    logic              done;
    logic [4:0]        hex_dec;
    logic [15:0]       code;
    logic [7:0]        esc_byte;
    logic              esc_ok;

    // Decode when a byte is held and the buffer can take its results.
    assign process  = in_vld_reg && can_load;
    assign s_tready = !in_vld_reg || process;

    assign hex_dec = jsu_pkg::hex_digit(in_byte_reg);
    assign code    = {acc_reg[11:0], hex_dec[3:0]};

    // Single-byte escapes.
    always_comb
    begin
        esc_ok   = 1'b1;
        esc_byte = in_byte_reg;
        case (in_byte_reg)
            jsu_pkg::CHAR_QUOTE,
            jsu_pkg::CHAR_BACKSLASH,
            jsu_pkg::CHAR_SLASH: esc_byte = in_byte_reg;
            jsu_pkg::CHAR_N:     esc_byte = jsu_pkg::BYTE_LF;
            jsu_pkg::CHAR_R:     esc_byte = jsu_pkg::BYTE_CR;
            jsu_pkg::CHAR_T:     esc_byte = jsu_pkg::BYTE_HT;
            jsu_pkg::CHAR_B:     esc_byte = jsu_pkg::BYTE_BS;
            jsu_pkg::CHAR_F:     esc_byte = jsu_pkg::BYTE_FF;
            default:             esc_ok   = 1'b0;
        endcase
    end

    // Next scanner state and the results of the held byte.
    always_comb
    begin
        mode_next      = mode_reg;
        hex_next       = hex_reg;
        acc_next       = acc_reg;
        res_next.count = 2'd0;
        res_next.bytes = '0;
        res_next.kind  = jsu_pkg::KIND_DATA;
        res_next.last  = 1'b0;
        done           = 1'b0;

        unique case (mode_reg)
            MODE_IDLE:
            begin
                if (in_byte_reg != jsu_pkg::CHAR_QUOTE)
                begin
                    done = 1'b1;
                end
                else
                begin
                    mode_next = MODE_TEXT;
                end
            end
            MODE_TEXT:
            begin
                if (in_byte_reg == jsu_pkg::CHAR_QUOTE)
                begin
                    mode_next      = MODE_IDLE;
                    res_next.count = 2'd1;
                    res_next.kind  = jsu_pkg::KIND_CLOSE;
                    res_next.last  = 1'b1;
                    done           = 1'b1;
                end
                else if (in_byte_reg < jsu_pkg::CHAR_SPACE)
                begin
                    done = 1'b1;
                end
                else if (in_byte_reg == jsu_pkg::CHAR_BACKSLASH)
                begin
                    mode_next = MODE_ESC;
                end
                else
                begin
                    res_next.count    = 2'd1;
                    res_next.bytes[0] = in_byte_reg;
                end
            end
            MODE_ESC:
            begin
                if (in_byte_reg == jsu_pkg::CHAR_U)
                begin
                    mode_next = MODE_HEX;
                    hex_next  = 2'd0;
                    acc_next  = 16'd0;
                end
                else if (esc_ok)
                begin
                    mode_next         = MODE_TEXT;
                    res_next.count    = 2'd1;
                    res_next.bytes[0] = esc_byte;
                end
                else
                begin
                    done = 1'b1;
                end
            end
            MODE_HEX:
            begin
                if (!hex_dec[4])
                begin
                    done = 1'b1;
                end
                else if (hex_reg != 2'd3)
                begin
                    hex_next = hex_reg + 2'd1;
                    acc_next = code;
                end
                else if (code >= jsu_pkg::SURR_LOW && code <= jsu_pkg::SURR_HIGH)
                begin
                    done = 1'b1;
                end
                else
                begin
                    mode_next = MODE_TEXT;
                    hex_next  = 2'd0;
                    acc_next  = 16'd0;
                    if (code < jsu_pkg::LIMIT_ONE)
                    begin
                        res_next.count    = 2'd1;
                        res_next.bytes[0] = code[7:0];
                    end
                    else if (code < jsu_pkg::LIMIT_TWO)
                    begin
                        res_next.count    = 2'd2;
                        res_next.bytes[0] = jsu_pkg::LEAD_TWO | {3'b000, code[10:6]};
                        res_next.bytes[1] = jsu_pkg::CONT_MARK | {2'b00, code[5:0]};
                    end
                    else
                    begin
                        res_next.count    = 2'd3;
                        res_next.bytes[0] = jsu_pkg::LEAD_THREE | {4'h0, code[15:12]};
                        res_next.bytes[1] = jsu_pkg::CONT_MARK | {2'b00, code[11:6]};
                        res_next.bytes[2] = jsu_pkg::CONT_MARK | {2'b00, code[5:0]};
                    end
                end
            end
            default:
            begin
                mode_next = MODE_IDLE;
            end
        endcase

        // An error found in the byte itself: one error result without tlast.
        if (done && res_next.kind != jsu_pkg::KIND_CLOSE)
        begin
            mode_next      = MODE_IDLE;
            hex_next       = 2'd0;
            acc_next       = 16'd0;
            res_next.count = 2'd1;
            res_next.bytes = '0;
            res_next.kind  = jsu_pkg::KIND_ERROR;
            res_next.last  = 1'b0;
        end
        // Input ran out inside a string: the string fails.
        else if (!done && in_final_reg)
        begin
            mode_next      = MODE_IDLE;
            hex_next       = 2'd0;
            acc_next       = 16'd0;
            res_next.count = 2'd1;
            res_next.bytes = '0;
            res_next.kind  = jsu_pkg::KIND_ERROR;
            res_next.last  = 1'b1;
        end
        else if (!done)
        begin
            res_next.last = (res_next.count != 2'd0);
        end
    end

    // Scanner state and input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_IDLE;
            hex_reg    <= 2'd0;
            acc_reg    <= 16'd0;
            in_vld_reg <= 1'b0;
        end
        else
        begin
            if (process)
            begin
                mode_reg <= mode_next;
                hex_reg  <= hex_next;
                acc_reg  <= acc_next;
            end
            if (s_tready)
            begin
                in_vld_reg <= s_tvalid;
            end
        end
    end

    // Input payload.
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg  <= s_tdata;
            in_final_reg <= s_tlast;
        end
    end

    jsu_result_buf u_result_buf
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (process),
        .result   (res_next),
        .can_load (can_load),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

/* hw/rtl/jsu_checker.sv */
// Port-level checker for the JSON string unescaper, bound to the top level.
// Depends on jsu_pkg and json_string_unescaper_unit.
module jsu_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic [1:0] m_tuser,
    input logic       m_tlast
);

    // A stalled result transaction holds its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("stalled result changed");

    // Close and error results carry a zero byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != jsu_pkg::KIND_DATA |-> m_tdata == 8'h00)
        else $error("non-data result with nonzero byte");

    // A close result is always the final one of its input byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == jsu_pkg::KIND_CLOSE |-> m_tlast)
        else $error("close result without tlast");

    // A UTF-8 lead or middle byte is followed at once by the rest of its sequence.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && m_tuser == jsu_pkg::KIND_DATA && !m_tlast
            |=> m_tvalid && m_tuser == jsu_pkg::KIND_DATA && m_tdata[7:6] == 2'b10)
        else $error("multi-byte sequence broken");

    // With no result pending the input side is always ready.
    assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with an empty output");

endmodule

bind json_string_unescaper_unit jsu_checker u_jsu_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
